>>> rtl/nixie_pkg.sv
// ----------------------------------------------------------------------------
// nixie_pkg
// Shared types and constants for the tube clock time and display controller.
// ----------------------------------------------------------------------------
package nixie_pkg;

    localparam int MAX_DIGITS = 6;

    typedef enum logic [3:0] {
        MODE_TICK        = 4'd0,
        MODE_POWER       = 4'd1,
        MODE_ALWAYS_ON   = 4'd2,
        MODE_HOUR_UP     = 4'd3,
        MODE_MINUTE_UP   = 4'd4,
        MODE_HOUR_HOLD   = 4'd5,
        MODE_MINUTE_HOLD = 4'd6,
        MODE_LOAD        = 4'd7,
        MODE_SAVED       = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        CFG_AUTO_OFF     = 3'd0,
        CFG_ANTI_POISON  = 3'd1,
        CFG_WINDOW_START = 3'd2,
        CFG_WINDOW_END   = 3'd3,
        CFG_INVERT       = 3'd4
    } cfg_reg_t;

    // result payload, first member at the top bit
    typedef struct packed {
        logic       pad;
        logic [5:0] second_now;
        logic [5:0] minute_now;
        logic [4:0] hour_now;
        logic       anti_poison_request;
        logic       settings_save_pending;
        logic       time_save_pending;
        logic       always_on_flag;
        logic       display_lit;
        logic       dots_lit;
        logic [15:0] tube_word;
    } result_t;

    // shift register pin for each digit position and bcd bit
    localparam logic [4:0] PIN_MAP [MAX_DIGITS][4] = '{
        '{5'd7,  5'd5,  5'd4,  5'd6},
        '{5'd3,  5'd1,  5'd0,  5'd2},
        '{5'd15, 5'd13, 5'd12, 5'd14},
        '{5'd11, 5'd9,  5'd8,  5'd10},
        '{5'd23, 5'd21, 5'd20, 5'd22},
        '{5'd19, 5'd17, 5'd16, 5'd18}
    };

    localparam logic [15:0] WORD_OFF = 16'hFFFF;
    localparam logic [15:0] SAT_MAX  = 16'hFFFF;

    // two bcd digits of a value below 64, tens in the upper nibble
    function automatic logic [7:0] bcd_split(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] rest;
        if (v >= 6'd60) begin
            tens = 4'd6;
        end else if (v >= 6'd50) begin
            tens = 4'd5;
        end else if (v >= 6'd40) begin
            tens = 4'd4;
        end else if (v >= 6'd30) begin
            tens = 4'd3;
        end else if (v >= 6'd20) begin
            tens = 4'd2;
        end else if (v >= 6'd10) begin
            tens = 4'd1;
        end else begin
            tens = 4'd0;
        end
        rest = v - 6'(tens) * 6'd10;
        return {tens, rest[3:0]};
    endfunction

endpackage

>>> rtl/nixie_clock_time_display_controller_unit.sv
// ----------------------------------------------------------------------------
// nixie_clock_time_display_controller_unit
// Time keeping, display power, dots and setting state for a tube clock.
// ----------------------------------------------------------------------------
// Each event transfer on the input stream (tick, key press, hold repeat, time
// load, save acknowledge) yields exactly one result transfer carrying the tube
// driver word, status flags and the current time. One event is taken every
// clock cycle while the skid entry is empty: the complete state update runs
// in a single combinational pass from the state registers into the state and
// result registers, and a two-entry output stage keeps accepting events while
// one result waits on a stalled output. A result is registered in the output
// register, or in the skid entry behind it. Configuration writes take effect
// at the next cycle and are meant to happen while no event is in flight.
module nixie_clock_time_display_controller_unit #(
    parameter int NUM_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    // event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // load_hour[4:0], load_minute[10:5], load_second[16:11]
    input  logic        s_tlast,
    input  logic [3:0]  s_tuser,   // mode[3:0]
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // tube_word[15:0], dots_lit[16], display_lit[17],
                                   // always_on_flag[18], time_save_pending[19],
                                   // settings_save_pending[20], anti_poison_request[21],
                                   // hour_now[26:22], minute_now[32:27], second_now[38:33]
);
    import nixie_pkg::*;

    // configuration
    logic [15:0] auto_off_reg;
    logic [15:0] anti_poison_reg;
    logic [10:0] win_start_reg;
    logic [10:0] win_end_reg;
    logic        invert_reg;

    // clock state
    logic [4:0]  hour_reg,   hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic        display_on_reg, display_on_next;
    logic        dots_on_reg, dots_on_next;
    logic        always_on_reg, always_on_next;
    logic        setting_reg, setting_next;
    logic        time_dirty_reg, time_dirty_next;
    logic        settings_dirty_reg, settings_dirty_next;
    logic [15:0] since_on_reg, since_on_next;
    logic [15:0] since_sweep_reg, since_sweep_next;
    logic [15:0] word_reg, word_next;
    logic        request;

    // output stage
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_data_reg, skid_data_next;
    result_t     result;

    logic        accept;
    mode_t       mode;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;

    // ticked time and window test
    logic [5:0]  tick_second;
    logic [5:0]  tick_minute;
    logic [4:0]  tick_hour;
    logic [10:0] tick_mod;
    logic        in_window;
    logic [15:0] tick_since_on;
    logic [15:0] tick_since_sweep;

    // bumped time for key presses
    logic [4:0]  bump_hour;
    logic [5:0]  bump_minute;

    logic [3:0]  digit_val [MAX_DIGITS];
    logic [7:0]  hour_bcd, minute_bcd, second_bcd;
    logic [15:0] shown_word;

    assign s_tready    = !skid_valid_reg;
    assign accept      = s_tvalid && s_tready;
    assign mode        = mode_t'(s_tuser);
    assign load_hour   = s_tdata[4:0];
    assign load_minute = s_tdata[10:5];
    assign load_second = s_tdata[16:11];

    always_comb begin
        tick_second = second_reg + 6'd1;
        tick_minute = minute_reg;
        tick_hour   = hour_reg;
        if (tick_second >= 6'd60) begin
            tick_second = 6'd0;
            tick_minute = minute_reg + 6'd1;
            if (tick_minute >= 6'd60) begin
                tick_minute = 6'd0;
                tick_hour   = (hour_reg >= 5'd23) ? 5'd0 : hour_reg + 5'd1;
            end
        end
    end

    // minute of day: hour * 60 = hour * 64 - hour * 4
    assign tick_mod = {tick_hour, 6'b0} - {4'b0, tick_hour, 2'b0} + {5'b0, tick_minute};

    assign in_window = (win_start_reg <= win_end_reg)
        ? (tick_mod >= win_start_reg && tick_mod < win_end_reg)
        : (tick_mod >= win_start_reg || tick_mod < win_end_reg);

    assign tick_since_on    = (since_on_reg == SAT_MAX) ? SAT_MAX : since_on_reg + 16'd1;
    assign tick_since_sweep = (since_sweep_reg == SAT_MAX) ? SAT_MAX : since_sweep_reg + 16'd1;

    assign bump_hour   = (hour_reg >= 5'd23) ? 5'd0 : hour_reg + 5'd1;
    assign bump_minute = (minute_reg >= 6'd59) ? 6'd0 : minute_reg + 6'd1;

    // time after this event
    always_comb begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        unique case (mode)
            MODE_TICK: begin
                if (!setting_reg) begin
                    hour_next   = tick_hour;
                    minute_next = tick_minute;
                    second_next = tick_second;
                end
            end
            MODE_HOUR_UP, MODE_HOUR_HOLD: begin
                hour_next = bump_hour;
            end
            MODE_MINUTE_UP, MODE_MINUTE_HOLD: begin
                minute_next = bump_minute;
            end
            MODE_LOAD: begin
                if (!setting_reg && !time_dirty_reg) begin
                    hour_next   = (load_hour > 5'd23) ? 5'd23 : load_hour;
                    minute_next = (load_minute > 6'd59) ? 6'd59 : load_minute;
                    second_next = (load_second > 6'd59) ? 6'd59 : load_second;
                end
            end
            default: begin
            end
        endcase
    end

    // tube word for the time after this event
    assign hour_bcd   = bcd_split({1'b0, hour_next});
    assign minute_bcd = bcd_split(minute_next);
    assign second_bcd = bcd_split(second_next);

    always_comb begin
        digit_val[0] = hour_bcd[7:4];
        digit_val[1] = hour_bcd[3:0];
        digit_val[2] = minute_bcd[7:4];
        digit_val[3] = minute_bcd[3:0];
        digit_val[4] = second_bcd[7:4];
        digit_val[5] = second_bcd[3:0];
    end

    always_comb begin
        logic [2:0] pos;
        logic [4:0] pin;
        shown_word = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            pos = invert_reg ? 3'(NUM_DIGITS - 1 - d) : 3'(d);
            for (int b = 0; b < 4; b++) begin
                pin = PIN_MAP[pos][b];
                if (digit_val[d][b] && pin < 5'd16) begin
                    shown_word[pin[3:0]] = 1'b1;
                end
            end
        end
    end

    // event handling
    always_comb begin
        display_on_next     = display_on_reg;
        dots_on_next        = dots_on_reg;
        always_on_next      = always_on_reg;
        setting_next        = setting_reg;
        time_dirty_next     = time_dirty_reg;
        settings_dirty_next = settings_dirty_reg;
        since_on_next       = since_on_reg;
        since_sweep_next    = since_sweep_reg;
        word_next           = word_reg;
        request             = 1'b0;

        unique case (mode)
            MODE_TICK: begin
                if (!setting_reg) begin
                    since_on_next    = tick_since_on;
                    since_sweep_next = tick_since_sweep;
                    if (!always_on_reg && !in_window && tick_since_on >= auto_off_reg) begin
                        display_on_next = 1'b0;
                    end
                    if (display_on_reg && !display_on_next) begin
                        dots_on_next = 1'b0;
                        word_next    = WORD_OFF;
                    end else if (display_on_next) begin
                        word_next    = shown_word;
                        dots_on_next = !dots_on_reg;
                        if (tick_since_sweep >= anti_poison_reg) begin
                            request          = 1'b1;
                            since_sweep_next = '0;
                        end
                    end
                end
            end
            MODE_POWER: begin
                if (display_on_reg) begin
                    display_on_next = 1'b0;
                    dots_on_next    = 1'b0;
                    word_next       = WORD_OFF;
                end else begin
                    display_on_next = 1'b1;
                    word_next       = shown_word;
                    since_on_next   = '0;
                end
            end
            MODE_ALWAYS_ON: begin
                display_on_next     = 1'b1;
                since_on_next       = '0;
                if (!display_on_reg) begin
                    word_next = shown_word;
                end
                always_on_next      = !always_on_reg;
                settings_dirty_next = 1'b1;
            end
            MODE_HOUR_UP, MODE_MINUTE_UP: begin
                display_on_next = 1'b1;
                since_on_next   = '0;
                word_next       = shown_word;
                time_dirty_next = 1'b1;
            end
            MODE_HOUR_HOLD, MODE_MINUTE_HOLD: begin
                display_on_next = 1'b1;
                since_on_next   = '0;
                dots_on_next    = 1'b0;
                word_next = shown_word;
                if (s_tlast) begin
                    time_dirty_next = 1'b1;
                    setting_next    = 1'b0;
                end else begin
                    setting_next = 1'b1;
                end
            end
            MODE_LOAD: begin
            end
            MODE_SAVED: begin
                settings_dirty_next = 1'b0;
                if (!setting_reg) begin
                    time_dirty_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.pad                   = 1'b0;
        result.second_now            = second_next;
        result.minute_now            = minute_next;
        result.hour_now              = hour_next;
        result.anti_poison_request   = request;
        result.settings_save_pending = settings_dirty_next;
        result.time_save_pending     = time_dirty_next && !setting_next;
        result.always_on_flag        = always_on_next;
        result.display_lit           = display_on_next;
        result.dots_lit              = dots_on_next;
        result.tube_word             = word_next;
    end

    // output register with a skid entry behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            out_valid_next  = skid_valid_reg || accept;
            out_data_next   = skid_valid_reg ? skid_data_reg : result;
            skid_valid_next = 1'b0;
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
        if (!aresetn) begin
            auto_off_reg       <= 16'd600;
            anti_poison_reg    <= 16'd1200;
            win_start_reg      <= 11'd570;
            win_end_reg        <= 11'd1410;
            invert_reg         <= 1'b0;
            hour_reg           <= '0;
            minute_reg         <= '0;
            second_reg         <= '0;
            display_on_reg     <= 1'b1;
            dots_on_reg        <= 1'b1;
            always_on_reg      <= 1'b1;
            setting_reg        <= 1'b0;
            time_dirty_reg     <= 1'b0;
            settings_dirty_reg <= 1'b0;
            since_on_reg       <= '0;
            since_sweep_reg    <= '0;
            word_reg           <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_addr))
                    CFG_AUTO_OFF:     auto_off_reg    <= cfg_wr_data;
                    CFG_ANTI_POISON:  anti_poison_reg <= cfg_wr_data;
                    CFG_WINDOW_START: win_start_reg   <= cfg_wr_data[10:0];
                    CFG_WINDOW_END:   win_end_reg     <= cfg_wr_data[10:0];
                    CFG_INVERT:       invert_reg      <= cfg_wr_data[0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                hour_reg           <= hour_next;
                minute_reg         <= minute_next;
                second_reg         <= second_next;
                display_on_reg     <= display_on_next;
                dots_on_reg        <= dots_on_next;
                always_on_reg      <= always_on_next;
                setting_reg        <= setting_next;
                time_dirty_reg     <= time_dirty_next;
                settings_dirty_reg <= settings_dirty_next;
                since_on_reg       <= since_on_next;
                since_sweep_reg    <= since_sweep_next;
                word_reg           <= word_next;
            end
        end
    end

    // skid entry only fills behind a held output
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output valid");

    // a dark display always drives the blank word with dots off
    assert property (@(posedge aclk) disable iff (!aresetn)
        !display_on_reg |-> (word_reg == WORD_OFF) && !dots_on_reg)
        else $error("display off but word or dots lit");

    // time of day stays in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        hour_reg < 5'd24 && minute_reg < 6'd60 && second_reg < 6'd60)
        else $error("time counter out of range");

    // a sweep request only goes out with the display on
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.anti_poison_request |-> out_data_reg.display_lit)
        else $error("sweep request while display off");

    // a stalled result stays valid and unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("held result changed");

endmodule
